[rtl/ps2d_pkg.sv]
package ps2d_pkg;

    localparam int unsigned COORD_W = 10;
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_X_MAX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX = 2'd1;

    localparam logic [COORD_W-1:0] X_MAX_RESET = 10'd600;
    localparam logic [COORD_W-1:0] Y_MAX_RESET = 10'd400;
    localparam logic [COORD_W-1:0] POS_X_RESET = 10'd400;
    localparam logic [COORD_W-1:0] POS_Y_RESET = 10'd300;

    localparam logic EV_KEY     = 1'b0;
    localparam logic EV_POINTER = 1'b1;

    typedef enum logic [1:0] {
        PH_FLAGS = 2'd0,
        PH_DX    = 2'd1,
        PH_DY    = 2'd2,
        PH_SPARE = 2'd3
    } phase_t;

    // Scancode set 1 to ASCII, US layout
    function automatic logic [CHAR_W-1:0] key_lookup(input logic [6:0] code);
        logic [CHAR_W-1:0] c;
        begin
            c = '0;
            unique case (code)
                7'd1:  c = 7'h1b;
                7'd2:  c = 7'h31;
                7'd3:  c = 7'h32;
                7'd4:  c = 7'h33;
                7'd5:  c = 7'h34;
                7'd6:  c = 7'h35;
                7'd7:  c = 7'h36;
                7'd8:  c = 7'h37;
                7'd9:  c = 7'h38;
                7'd10: c = 7'h39;
                7'd11: c = 7'h30;
                7'd12: c = 7'h2d;
                7'd13: c = 7'h3d;
                7'd14: c = 7'h08;
                7'd15: c = 7'h09;
                7'd16: c = 7'h71;
                7'd17: c = 7'h77;
                7'd18: c = 7'h65;
                7'd19: c = 7'h72;
                7'd20: c = 7'h74;
                7'd21: c = 7'h79;
                7'd22: c = 7'h75;
                7'd23: c = 7'h69;
                7'd24: c = 7'h6f;
                7'd25: c = 7'h70;
                7'd26: c = 7'h5b;
                7'd27: c = 7'h5d;
                7'd28: c = 7'h0a;
                7'd30: c = 7'h61;
                7'd31: c = 7'h73;
                7'd32: c = 7'h64;
                7'd33: c = 7'h66;
                7'd34: c = 7'h67;
                7'd35: c = 7'h68;
                7'd36: c = 7'h6a;
                7'd37: c = 7'h6b;
                7'd38: c = 7'h6c;
                7'd39: c = 7'h3b;
                7'd40: c = 7'h27;
                7'd41: c = 7'h60;
                7'd43: c = 7'h5c;
                7'd44: c = 7'h7a;
                7'd45: c = 7'h78;
                7'd46: c = 7'h63;
                7'd47: c = 7'h76;
                7'd48: c = 7'h62;
                7'd49: c = 7'h6e;
                7'd50: c = 7'h6d;
                7'd51: c = 7'h2c;
                7'd52: c = 7'h2e;
                7'd53: c = 7'h2f;
                7'd55: c = 7'h2a;
                7'd57: c = 7'h20;
                default: c = '0;
            endcase
            return c;
        end
    endfunction

endpackage

[rtl/ps2d_mouse.sv]
module ps2d_mouse
    import ps2d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         data_byte,
    input  logic [COORD_W-1:0] x_max,
    input  logic [COORD_W-1:0] y_max,
    output logic               emit,
    output logic [COORD_W-1:0] new_x,
    output logic [COORD_W-1:0] new_y
);

    phase_t             phase_reg, phase_next;
    logic [7:0]         held_dx_reg;
    logic [COORD_W-1:0] pos_x_reg, pos_y_reg;

    logic signed [COORD_W+1:0] nx, ny;

    always_comb
    begin
        nx = $signed({2'b00, pos_x_reg}) + $signed({{(COORD_W-6){held_dx_reg[7]}}, held_dx_reg});
        ny = $signed({2'b00, pos_y_reg}) - $signed({{(COORD_W-6){data_byte[7]}}, data_byte});
        if (nx[COORD_W+1])
            new_x = '0;
        else if (nx[COORD_W:0] > {1'b0, x_max})
            new_x = x_max;
        else
            new_x = nx[COORD_W-1:0];
        if (ny[COORD_W+1])
            new_y = '0;
        else if (ny[COORD_W:0] > {1'b0, y_max})
            new_y = y_max;
        else
            new_y = ny[COORD_W-1:0];
    end

    assign emit = (phase_reg == PH_DY);

    always_comb
    begin
        unique case (phase_reg)
            PH_DX:   phase_next = PH_DY;
            PH_DY:   phase_next = PH_FLAGS;
            default: phase_next = PH_DX;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_FLAGS;
            held_dx_reg <= '0;
            pos_x_reg   <= POS_X_RESET;
            pos_y_reg   <= POS_Y_RESET;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            if (phase_reg == PH_DX)
                held_dx_reg <= data_byte;
            if (phase_reg == PH_DY)
            begin
                pos_x_reg <= new_x;
                pos_y_reg <= new_y;
            end
        end
    end

endmodule

[rtl/ps2d_keys.sv]
module ps2d_keys
    import ps2d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    output logic              emit,
    output logic [CHAR_W-1:0] key_char
);

    logic [7:0] last_code_reg;

    assign emit     = !data_byte[7] && (data_byte != last_code_reg);
    assign key_char = key_lookup(data_byte[6:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_code_reg <= '0;
        else if (step)
            last_code_reg <= data_byte;
    end

endmodule

[rtl/ps2_input_decoder.sv]
// PS/2 byte decoder. Each input word is one byte from the controller, tagged
// byte_ready and from_aux (mouse). Mouse bytes form three-byte packets; the
// third byte moves the pointer and yields a pointer word clamped to
// 0..x_max / 0..y_max. Keyboard bytes are scancode set 1: break codes and
// repeated make codes give no output, other make codes give an ASCII word
// from a fixed US keymap (unmapped codes give 0). One word is taken per
// cycle; a word passes an input register and, if it yields output, the
// result register, whose valid flag is out_valid. A result that is not
// taken holds back the next word that yields output. The config port is
// always ready and should only be written while the block is idle.
module ps2_input_decoder
    import ps2d_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 byte_ready,
    input  logic                 from_aux,
    input  logic [7:0]           data_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 event_kind,
    output logic [CHAR_W-1:0]    key_char,
    output logic [COORD_W-1:0]   pointer_x,
    output logic [COORD_W-1:0]   pointer_y,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data
);

    logic                 iv_reg;
    logic                 rdy_reg, aux_reg;
    logic [7:0]           byte_reg;
    logic [COORD_W-1:0]   x_max_reg, y_max_reg;

    logic                 ov_reg, kind_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic [COORD_W-1:0]   px_reg, py_reg;

    logic                 m_emit, k_emit, produce, out_free, advance;
    logic                 m_step, k_step;
    logic [COORD_W-1:0]   m_x, m_y;
    logic [CHAR_W-1:0]    k_char;

    assign produce  = rdy_reg && (aux_reg ? m_emit : k_emit);
    assign out_free = !ov_reg || out_ready;
    assign advance  = iv_reg && (!produce || out_free);
    assign in_ready = !iv_reg || advance;
    assign m_step   = advance && rdy_reg && aux_reg;
    assign k_step   = advance && rdy_reg && !aux_reg;
    assign cfg_ready = 1'b1;

    ps2d_mouse u_mouse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (m_step),
        .data_byte (byte_reg),
        .x_max     (x_max_reg),
        .y_max     (y_max_reg),
        .emit      (m_emit),
        .new_x     (m_x),
        .new_y     (m_y)
    );

    ps2d_keys u_keys
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (k_step),
        .data_byte (byte_reg),
        .emit      (k_emit),
        .key_char  (k_char)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
            x_max_reg <= X_MAX_RESET;
            y_max_reg <= Y_MAX_RESET;
        end
        else
        begin
            if (in_ready)
                iv_reg <= in_valid;
            if (advance && produce)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
            if (cfg_valid && cfg_index == CFG_X_MAX)
                x_max_reg <= cfg_data;
            if (cfg_valid && cfg_index == CFG_Y_MAX)
                y_max_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rdy_reg  <= byte_ready;
            aux_reg  <= from_aux;
            byte_reg <= data_byte;
        end
        if (advance && produce)
        begin
            kind_reg <= aux_reg ? EV_POINTER : EV_KEY;
            char_reg <= aux_reg ? '0 : k_char;
            px_reg   <= aux_reg ? m_x : '0;
            py_reg   <= aux_reg ? m_y : '0;
        end
    end

    assign out_valid  = ov_reg;
    assign event_kind = kind_reg;
    assign key_char   = char_reg;
    assign pointer_x  = px_reg;
    assign pointer_y  = py_reg;

endmodule
